// File: design/ook_pwm_frame_encoder_assert.svh
// Assertion macros shared by the encoder RTL.
// All of them sample on clk_i and are disabled while rst_ni is low.
`ifndef OOK_PWM_FRAME_ENCODER_ASSERT_SVH
`define OOK_PWM_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define OOKPWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OOKPWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ookpwm_pkg.sv
package ookpwm_pkg;

  localparam int unsigned FrameBits = 24;

  // Command field values
  localparam logic [2:0] CMD_STOP     = 3'd0;
  localparam logic [2:0] CMD_FORWARD  = 3'd1;
  localparam logic [2:0] CMD_BACKWARD = 3'd2;
  localparam logic [2:0] CMD_LEFT     = 3'd3;
  localparam logic [2:0] CMD_RIGHT    = 3'd4;

  // Frame codes for the low nibble
  localparam logic [3:0] CODE_STOP     = 4'h0;
  localparam logic [3:0] CODE_FORWARD  = 4'h1;
  localparam logic [3:0] CODE_BACKWARD = 4'h2;
  localparam logic [3:0] CODE_LEFT     = 4'h4;
  localparam logic [3:0] CODE_RIGHT    = 4'h8;

  typedef enum logic [2:0] {
    CFG_DEVICE_ADDRESS    = 3'd0,
    CFG_REPEAT_COUNT      = 3'd1,
    CFG_AMPLITUDE         = 3'd2,
    CFG_SAMPLES_PER_PULSE = 3'd3,
    CFG_SYNC_PULSES       = 3'd4,
    CFG_BIT_PULSES        = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SYNC_HI = 2'd0,
    PH_SYNC_LO = 2'd1,
    PH_BIT_HI  = 2'd2,
    PH_BIT_LO  = 2'd3
  } phase_e;

  typedef struct packed {
    logic        start_req;
    logic [2:0]  command;
  } in_req_t;

  typedef struct packed {
    logic        active;
    logic        level;
    logic [14:0] i_sample;
    logic        last;
  } out_rsp_t;

  typedef struct packed {
    logic [19:0] device_address;
    logic [3:0]  repeat_count;
    logic [14:0] amplitude;
    logic [11:0] samples_per_pulse;
    logic [15:0] sync_pulses;
    logic [31:0] bit_pulses;
  } cfg_t;

  function automatic logic [3:0] cmd_code(logic [2:0] cmd);
    logic [3:0] code;
    case (cmd)
      CMD_FORWARD:  code = CODE_FORWARD;
      CMD_BACKWARD: code = CODE_BACKWARD;
      CMD_LEFT:     code = CODE_LEFT;
      CMD_RIGHT:    code = CODE_RIGHT;
      default:      code = CODE_STOP;
    endcase
    return code;
  endfunction

endpackage

// File: design/ookpwm_cfg.sv
module ookpwm_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output ookpwm_pkg::cfg_t    cfg_o
);
  import ookpwm_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEVICE_ADDRESS:    cfg_d.device_address    = cfg_data_i[19:0];
        CFG_REPEAT_COUNT:      cfg_d.repeat_count      = cfg_data_i[3:0];
        CFG_AMPLITUDE:         cfg_d.amplitude         = cfg_data_i[14:0];
        CFG_SAMPLES_PER_PULSE: cfg_d.samples_per_pulse = cfg_data_i[11:0];
        CFG_SYNC_PULSES:       cfg_d.sync_pulses       = cfg_data_i[15:0];
        CFG_BIT_PULSES:        cfg_d.bit_pulses        = cfg_data_i;
        default:               cfg_d = cfg_q;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= 20'd0;
      cfg_q.repeat_count      <= 4'd1;
      cfg_q.amplitude         <= 15'h7FFF;
      cfg_q.samples_per_pulse <= 12'd1;
      cfg_q.sync_pulses       <= 16'd0;
      cfg_q.bit_pulses        <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/ookpwm_step.sv
module ookpwm_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  ookpwm_pkg::in_req_t   req_i,
  input  ookpwm_pkg::cfg_t      cfg_i,
  output ookpwm_pkg::out_rsp_t  rsp_o
);
  import ookpwm_pkg::*;

  logic        busy_q, busy_d;
  logic [23:0] frame_q, frame_d;
  logic [4:0]  bit_q, bit_d;
  phase_e      phase_q, phase_d;
  logic [19:0] cnt_q, cnt_d;
  logic [3:0]  rep_q, rep_d;

  // State as seen by this tick, after a possible start
  logic        start;
  logic        busy_v;
  logic [23:0] frame_v;
  logic [4:0]  bit_v;
  phase_e      phase_v;
  logic [19:0] cnt_v;
  logic [3:0]  rep_v;

  logic [4:0]  idx_c;
  logic [4:0]  bit_sel;
  logic        cur_bit;
  logic [7:0]  pulses;
  logic [19:0] seg_len;
  logic [19:0] seg_len_eff;
  logic [19:0] cnt_inc;
  logic        seg_done;
  logic [3:0]  rep_inc;
  logic [3:0]  reps;
  logic        level;
  logic        last;

  assign start   = !busy_q && req_i.start_req;
  assign busy_v  = busy_q || start;
  assign frame_v = start ? {cfg_i.device_address, cmd_code(req_i.command)} : frame_q;
  assign bit_v   = start ? 5'd0 : bit_q;
  assign phase_v = start ? PH_SYNC_HI : phase_q;
  assign cnt_v   = start ? 20'd0 : cnt_q;
  assign rep_v   = start ? 4'd0 : rep_q;

  assign idx_c   = (bit_v > 5'(FrameBits - 1)) ? 5'(FrameBits - 1) : bit_v;
  assign bit_sel = 5'(FrameBits - 1) - idx_c;
  assign cur_bit = frame_v[bit_sel];

  always_comb begin
    case (phase_v)
      PH_SYNC_HI: pulses = cfg_i.sync_pulses[15:8];
      PH_SYNC_LO: pulses = cfg_i.sync_pulses[7:0];
      PH_BIT_HI:  pulses = cur_bit ? cfg_i.bit_pulses[31:24] : cfg_i.bit_pulses[15:8];
      PH_BIT_LO:  pulses = cur_bit ? cfg_i.bit_pulses[23:16] : cfg_i.bit_pulses[7:0];
      default:    pulses = 8'd0;
    endcase
  end

  // 8 x 12 product always fits 20 bits
  assign seg_len     = 20'(pulses) * 20'(cfg_i.samples_per_pulse);
  assign seg_len_eff = (seg_len == 20'd0) ? 20'd1 : seg_len;
  assign cnt_inc     = cnt_v + 20'd1;
  assign seg_done    = cnt_inc >= seg_len_eff;
  assign rep_inc     = rep_v + 4'd1;
  assign reps        = (cfg_i.repeat_count == 4'd0) ? 4'd1 : cfg_i.repeat_count;
  assign level       = !phase_v[0];

  always_comb begin
    busy_d  = busy_v;
    frame_d = frame_v;
    bit_d   = bit_v;
    phase_d = phase_v;
    cnt_d   = cnt_v;
    rep_d   = rep_v;
    last    = 1'b0;
    if (busy_v) begin
      cnt_d = cnt_inc;
      if (seg_done) begin
        cnt_d = 20'd0;
        case (phase_v)
          PH_SYNC_HI: phase_d = PH_SYNC_LO;
          PH_SYNC_LO: begin
            phase_d = PH_BIT_HI;
            bit_d   = 5'd0;
          end
          PH_BIT_HI:  phase_d = PH_BIT_LO;
          default: begin
            if (bit_v < 5'(FrameBits - 1)) begin
              bit_d   = bit_v + 5'd1;
              phase_d = PH_BIT_HI;
            end else begin
              rep_d = rep_inc;
              if (rep_inc >= reps) begin
                busy_d = 1'b0;
                last   = 1'b1;
              end
              phase_d = PH_SYNC_HI;
              bit_d   = 5'd0;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    rsp_o.active   = busy_v;
    rsp_o.level    = busy_v && level;
    rsp_o.i_sample = (busy_v && level) ? cfg_i.amplitude : 15'd0;
    rsp_o.last     = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      frame_q <= 24'd0;
      bit_q   <= 5'd0;
      phase_q <= PH_SYNC_HI;
      cnt_q   <= 20'd0;
      rep_q   <= 4'd0;
    end else if (en_i) begin
      busy_q  <= busy_d;
      frame_q <= frame_d;
      bit_q   <= bit_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rep_q   <= rep_d;
    end
  end

endmodule

// File: design/ook_pwm_frame_encoder.sv
// OOK/PWM remote frame encoder, one output sample per input sample tick.
//
// Input channel (in_valid_i / in_stall_o / in_req_i): one request per sample
// tick, carrying start_req and command. A start while idle latches a 24-bit
// frame {device_address, command code} and that same tick gives the first sync
// high sample; a start while busy is ignored.
// Output channel (out_valid_o / out_stall_i / out_rsp_o): exactly one result
// per request: active, level, i_sample (amplitude when high), last.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): always
// ready; index 0..5 selects address, repeat count, amplitude, samples per
// pulse, sync pulses, bit pulses. Other indexes are dropped.
// Path: a taken request goes from the input register to the result register.
// Throughput: one request per cycle while not stalled; the input register feeds
// one pass of segment-length multiply and compare into the result register.
// Stall: while the result register is held, a single request waits in the
// input register and in_stall_o rises only once that register is occupied.
// Reset: both registers empty, encoder idle, config at its defaults.
`include "ook_pwm_frame_encoder_assert.svh"

module ook_pwm_frame_encoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ookpwm_pkg::in_req_t   in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ookpwm_pkg::out_rsp_t  out_rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);
  import ookpwm_pkg::*;

  cfg_t     cfg;
  in_req_t  s1_req_q;
  logic     s1_valid_q, s1_valid_d;
  out_rsp_t step_rsp;
  out_rsp_t out_rsp_q;
  logic     out_valid_q, out_valid_d;
  logic     adv;
  logic     in_take;

  ookpwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the held request into the result register when that slot frees up
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  ookpwm_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .req_i  (s1_req_q),
    .cfg_i  (cfg),
    .rsp_o  (step_rsp)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = adv ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_req_i;
    end
    if (adv) begin
      out_rsp_q <= step_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `OOKPWM_ASSERT_IMP(a_stall_needs_held_req, in_stall_o, s1_valid_q,
                     "input stalled with empty input register")
  `OOKPWM_ASSERT_IMP(a_no_adv_into_held, out_valid_q && out_stall_i, !adv,
                     "result register overwritten while stalled")
  `OOKPWM_ASSERT_IMP(a_last_is_active, out_valid_q && out_rsp_q.last, out_rsp_q.active,
                     "last flagged on an idle sample")
  `OOKPWM_ASSERT_NXT(a_adv_fills_out, adv, out_valid_q,
                     "advanced request did not reach the result register")

endmodule
